// ===== design/ssttl_pkg.sv =====
// types, constants and hash step functions for the set-associative ttl cache
// no dependencies; used by every other design file except ssttl_ram

package ssttl_pkg;

   localparam int SETS        = 256;
   localparam int WAYS        = 4;
   localparam int SET_BITS    = $clog2(SETS);
   localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TTL_BITS    = 31;
   localparam int TTL_US_BITS = 51;

   localparam logic [TTL_BITS-1:0] TTL_RESET  = 31'd3600;
   localparam logic [19:0]         US_PER_SEC = 20'd1000000;
   localparam logic [62:0]         STAMP_MAX  = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [31:0]         HASH_INIT  = 32'h9e3779b9 + 32'd12 + 32'd3923095;

   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_STORE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_MISS   = 2'd0,
      STATUS_HIT    = 2'd1,
      STATUS_STORED = 2'd2,
      STATUS_REJECT = 2'd3
   } status_type;

   typedef struct packed {
      logic               req_type;
      logic [31:0]        db_oid;
      logic [31:0]        rel_oid;
      logic signed [15:0] column_num;
      logic [62:0]        now_us;
      logic [63:0]        doc_count_in;
      logic [63:0]        token_count_in;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] doc_count_out;
      logic [63:0] token_count_out;
   } rsp_item_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] db;
      logic [31:0] rel;
      logic [15:0] col;
      logic [63:0] docs;
      logic [63:0] toks;
      logic [62:0] stamp;
   } entry_type;

   typedef entry_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } hash_state_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
      return (x << k) | (x >> (32 - k));
   endfunction

   // first half of the mix rounds
   function automatic hash_state_type mix_lo(input hash_state_type s);
      hash_state_type r;
      r = s;
      r.a = r.a - r.c; r.a = r.a ^ rotl(r.c, 4);  r.c = r.c + r.b;
      r.b = r.b - r.a; r.b = r.b ^ rotl(r.a, 6);  r.a = r.a + r.c;
      r.c = r.c - r.b; r.c = r.c ^ rotl(r.b, 8);  r.b = r.b + r.a;
      return r;
   endfunction

   function automatic hash_state_type mix_hi(input hash_state_type s);
      hash_state_type r;
      r = s;
      r.a = r.a - r.c; r.a = r.a ^ rotl(r.c, 16); r.c = r.c + r.b;
      r.b = r.b - r.a; r.b = r.b ^ rotl(r.a, 19); r.a = r.a + r.c;
      r.c = r.c - r.b; r.c = r.c ^ rotl(r.b, 4);  r.b = r.b + r.a;
      return r;
   endfunction

   function automatic hash_state_type fin_lo(input hash_state_type s);
      hash_state_type r;
      r = s;
      r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 14);
      r.a = r.a ^ r.c; r.a = r.a - rotl(r.c, 11);
      r.b = r.b ^ r.a; r.b = r.b - rotl(r.a, 25);
      r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 16);
      return r;
   endfunction

   function automatic hash_state_type fin_hi(input hash_state_type s);
      hash_state_type r;
      r = s;
      r.a = r.a ^ r.c; r.a = r.a - rotl(r.c, 4);
      r.b = r.b ^ r.a; r.b = r.b - rotl(r.a, 14);
      r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 24);
      return r;
   endfunction

endpackage

// ===== design/ssttl_if.sv =====
// request and response channel interfaces with valid/ready handshake
// depends on ssttl_pkg

interface ssttl_req_if import ssttl_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ssttl_rsp_if import ssttl_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/stat_set_assoc_ttl_cache_unit.sv =====
// Statistics cache, 4-way set associative, keyed by database id, relation id and column.
// After the accepting edge an item passes through the hash unit, one row read from the set memory,
// the per-way compares and the way selection with the write-back, and the result is registered.
// The next item is taken in the cycle after the result is set; a stalled result holds the
// decide cycle. One item is in flight at a time; the result register lets the next item enter
// while a result waits. After reset a clearing pass writes every one of the SETS (256) rows
// to zero, emptying the set memory before the first item is taken.
// Depends on ssttl_pkg, ssttl_if, ssttl_ram and ssttl_hash.

module stat_set_assoc_ttl_cache_unit import ssttl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   ssttl_req_if.sink           req_bus,
   ssttl_rsp_if.source         rsp_bus,
   input  logic                csr_we,
   input  logic [TTL_BITS-1:0] csr_wdata
);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_HASH   = 6'b000100,
      ST_READ   = 6'b001000,
      ST_EVAL   = 6'b010000,
      ST_DECIDE = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [SET_BITS-1:0]  clr_idx_ff, clr_idx_in;
   req_item_type         item_ff, item_in;
   logic [SET_BITS-1:0]  set_ff, set_in;
   logic [WAYS-1:0]      hit_ff, hit_in;
   logic [WAYS-1:0]      free_ff, free_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;
   logic [TTL_BITS-1:0]  ttl_ff, ttl_in;
   logic [TTL_US_BITS-1:0] ttl_us_ff, ttl_us_in;

   logic        accept;
   logic        hash_done;
   logic [31:0] hash_value;
   logic        wr_en;
   logic [SET_BITS-1:0] wr_addr;
   row_type     wr_row;
   row_type     rd_row;
   logic        rd_en;

   logic        bad_counts;
   logic        found;
   logic        stop;
   logic [WAY_BITS-1:0] slot;
   logic [62:0] oldest;
   logic        any_hit;
   logic [WAY_BITS-1:0] hit_way;
   row_type     new_row;
   logic        out_free;
   logic [63:0] age;
   logic        col_match;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign rd_en         = (state_ff == ST_READ);

   ssttl_hash u_hash (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .word0      (req_bus.payload.db_oid),
      .word1      (req_bus.payload.rel_oid),
      .word2      ({16'd0, req_bus.payload.column_num}),
      .done       (hash_done),
      .hash_value (hash_value)
   );

   ssttl_ram #(
      .WIDTH ($bits(row_type)),
      .DEPTH (SETS)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (hash_value[SET_BITS-1:0]),
      .rd_data (rd_row)
   );

   // per-way compare against the row just read
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         col_match  = (rd_row[w].col == item_ff.column_num);
         free_in[w] = !rd_row[w].valid ||
                      (rd_row[w].db == item_ff.db_oid && rd_row[w].rel == item_ff.rel_oid &&
                       col_match);
         age        = {1'b0, item_ff.now_us} - {1'b0, rd_row[w].stamp};
         hit_in[w]  = rd_row[w].valid && (rd_row[w].db == item_ff.db_oid) &&
                      (rd_row[w].rel == item_ff.rel_oid) && col_match &&
                      (rd_row[w].docs != 64'd0) && (rd_row[w].toks >= rd_row[w].docs) &&
                      !($signed(age) > $signed({13'd0, ttl_us_ff}));
      end
   end

   // way selection for lookup and store
   always_comb begin
      any_hit = 1'b0;
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_ff[w]) begin
            any_hit = 1'b1;
            hit_way = WAY_BITS'(w);
         end
      end
      found  = 1'b0;
      stop   = 1'b0;
      slot   = '0;
      oldest = STAMP_MAX;
      for (int w = 0; w < WAYS; w++) begin
         if (!stop) begin
            if (free_ff[w]) begin
               slot  = WAY_BITS'(w);
               found = 1'b1;
               stop  = 1'b1;
            end else if (rd_row[w].stamp < oldest) begin
               oldest = rd_row[w].stamp;
               slot   = WAY_BITS'(w);
               found  = 1'b1;
            end
         end
      end
      bad_counts = (item_ff.doc_count_in == 64'd0) ||
                   (item_ff.token_count_in < item_ff.doc_count_in);
      new_row             = rd_row;
      new_row[slot].valid = 1'b1;
      new_row[slot].db    = item_ff.db_oid;
      new_row[slot].rel   = item_ff.rel_oid;
      new_row[slot].col   = item_ff.column_num;
      new_row[slot].docs  = item_ff.doc_count_in;
      new_row[slot].toks  = item_ff.token_count_in;
      new_row[slot].stamp = item_ff.now_us;
   end

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      item_in      = item_ff;
      set_in       = set_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_item_in  = rsp_item_ff;
      ttl_in       = csr_we ? csr_wdata : ttl_ff;
      ttl_us_in    = TTL_US_BITS'(ttl_ff) * TTL_US_BITS'(US_PER_SEC);
      wr_en        = 1'b0;
      wr_addr      = set_ff;
      wr_row       = new_row;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_row     = '0;
            clr_idx_in = clr_idx_ff + SET_BITS'(1);
            if (clr_idx_ff == SET_BITS'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               item_in  = req_bus.payload;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            set_in   = hash_value[SET_BITS-1:0];
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_item_in.doc_count_out   = 64'd0;
               rsp_item_in.token_count_out = 64'd0;
               if (item_ff.req_type == REQ_LOOKUP) begin
                  if (any_hit) begin
                     rsp_item_in.status          = STATUS_HIT;
                     rsp_item_in.doc_count_out   = rd_row[hit_way].docs;
                     rsp_item_in.token_count_out = rd_row[hit_way].toks;
                  end else begin
                     rsp_item_in.status = STATUS_MISS;
                  end
               end else if (bad_counts || !found) begin
                  rsp_item_in.status = STATUS_REJECT;
               end else begin
                  rsp_item_in.status = STATUS_STORED;
                  wr_en              = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         ttl_ff       <= TTL_RESET;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         ttl_ff       <= ttl_in;
      end
      item_ff     <= item_in;
      set_ff      <= set_in;
      hit_ff      <= hit_in;
      free_ff     <= free_in;
      rsp_item_ff <= rsp_item_in;
      ttl_us_ff   <= ttl_us_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_item_ff;

   a_write_when_owned: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_DECIDE))
      else $error("set memory written outside clear or decide");

   a_hash_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> state_ff == ST_HASH)
      else $error("hash finished while not waiting for it");

   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DECIDE))
      else $error("result appeared without a decide cycle");

   a_store_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && wr_en) |=> rsp_item_ff.status == STATUS_STORED)
      else $error("row written but status is not stored");

endmodule

// ===== design/ssttl_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module ssttl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ssttl_hash.sv =====
// iterative key hash: mix and final rounds, applied in the order mix_lo, mix_hi, fin_lo, fin_hi
// depends on ssttl_pkg

module ssttl_hash import ssttl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] word0,
   input  logic [31:0] word1,
   input  logic [31:0] word2,
   output logic        done,
   output logic [31:0] hash_value
);

   hash_state_type st_ff, st_in;
   logic [1:0]     cnt_ff, cnt_in;
   logic           busy_ff, busy_in;

   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         st_in.a = HASH_INIT + word0;
         st_in.b = HASH_INIT + word1;
         st_in.c = HASH_INIT + word2;
         cnt_in  = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         case (cnt_ff)
            2'd0:    st_in = mix_lo(st_ff);
            2'd1:    st_in = mix_hi(st_ff);
            2'd2:    st_in = fin_lo(st_ff);
            default: st_in = fin_hi(st_ff);
         endcase
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      st_ff <= st_in;
   end

   // final state is in place the cycle after done
   assign done       = busy_ff && (cnt_ff == 2'd3);
   assign hash_value = st_ff.c;

endmodule
